// ===== rtl/core/sfvg_pkg.sv =====
// Package for the stroke font vector generator: widths, codes, Q16.16 helpers.
// Used by every module in rtl/core.
package sfvg_pkg;
	localparam int STROKE_WORDS_DEF  = 1024;
	localparam int CHAR_CODES_DEF    = 256;
	localparam int MAX_GLYPH_OPS_DEF = 30;

	localparam logic [2:0] OP_LOAD_WORD  = 3'd0;
	localparam logic [2:0] OP_LOAD_GLYPH = 3'd1;
	localparam logic [2:0] OP_SET_PEN    = 3'd2;
	localparam logic [2:0] OP_DRAW       = 3'd3;
	localparam logic [2:0] OP_INDENT     = 3'd4;

	localparam logic [1:0] KIND_BEGIN = 2'd0;
	localparam logic [1:0] KIND_VERT  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_DONE  = 2'd3;

	localparam logic [2:0] REG_SCALE_X = 3'd0;
	localparam logic [2:0] REG_SCALE_Y = 3'd1;

	// multiplier operand select
	typedef enum logic [2:0] {
		MS_ADV_SX, MS_AX_DIR, MS_X_SX, MS_Y_SY, MS_MAT_PX, MS_MAT_PY, MS_MAT_AX
	} msel_t;

	// accumulator action on the registered product
	typedef enum logic [2:0] {
		AC_NONE, AC_AX, AC_PX, AC_PY, AC_CLR_PEN, AC_ADD, AC_SAT_V, AC_SAT_PEN
	} acc_t;

	typedef struct packed {
		logic         mem_rd;     // read stroke word at walk address
		logic         addr_load;  // walk address from glyph offset
		logic         addr_inc;
		logic         latch_x;
		logic         latch_y;
		logic         latch_op;
		logic         mul_go;
		msel_t        msel;
		logic [1:0]   row;
		acc_t         acc;
		logic         pen_wr;     // write accumulated coordinate to pen[row]
		logic         ax_dir;     // set with AC_AX in ADVDR; sfvg_datapath does not read it
	} cmd_t;

	typedef struct packed {
		logic is_move;
		logic is_draw;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// round to nearest, ties up: floor((p + 2^15) / 2^16)
	function automatic logic signed [48:0] qrnd(input logic signed [63:0] p);
		logic signed [64:0] t;
		t = {p[63], p} + 65'sd32768;
		return t[64:16];
	endfunction
endpackage

// ===== rtl/core/sfvg_datapath.sv =====
// Datapath: stroke memory, glyph tables, pen, shared registered multiplier
// and accumulator. Depends on sfvg_pkg.
module sfvg_datapath import sfvg_pkg::*; #(
	parameter int STROKE_WORDS = STROKE_WORDS_DEF,
	parameter int CHAR_CODES   = CHAR_CODES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic signed [31:0]  cfg_data,
	input  logic                in_acc,
	input  logic [2:0]          op,
	input  logic [7:0]          char_code,
	input  logic [9:0]          table_addr,
	input  logic signed [31:0]  table_word,
	input  logic                glyph_present,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [31:0]  direction,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic                present,
	output logic signed [31:0]  acc_out,
	output logic signed [31:0]  pen_out [3]
);
	localparam int AW = $clog2(STROKE_WORDS);
	localparam int CW = $clog2(CHAR_CODES);

	logic signed [31:0] regs_q [8];
	logic signed [31:0] mem [STROKE_WORDS];
	logic signed [31:0] rd_q;
	logic [AW-1:0]      addr_q;
	logic [CHAR_CODES-1:0] gvalid_q;
	logic [9:0]         goff_q [CHAR_CODES];
	logic signed [31:0] gadv_q [CHAR_CODES];
	logic [CW-1:0]      code_q;
	logic signed [31:0] dir_q, x_q, y_q, px_q, py_q, ax_q, adv_q;
	logic [9:0]         off_q;
	logic signed [31:0] pen_q [3];
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod_s1;
	logic signed [48:0] rp;
	logic signed [65:0] sum_q;
	logic [1:0]         opc_q;
	logic               code_ok;

	assign code_ok = ({24'd0, char_code} < CHAR_CODES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{32'sd65536, 32'sd65536, 32'sd65536, 32'sd0, 32'sd0,
				32'sd65536, 32'sd0, 32'sd0};
			gvalid_q <= '0;
			pen_q <= '{32'sd0, 32'sd0, 32'sd0};
			present <= 1'b0;
		end else begin
			if (cfg_we) regs_q[cfg_idx] <= cfg_data;
			if (in_acc) begin
				if (op == OP_LOAD_GLYPH && code_ok)
					gvalid_q[char_code[CW-1:0]] <= glyph_present;
				if (op == OP_SET_PEN) pen_q <= '{pos_x, pos_y, pos_z};
				present <= code_ok && gvalid_q[char_code[CW-1:0]];
			end
			if (cmd.pen_wr) pen_q[cmd.row] <= acc_out;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (op == OP_LOAD_WORD && {22'd0, table_addr} < STROKE_WORDS)
				mem[AW'(table_addr)] <= table_word;
			if (op == OP_LOAD_GLYPH && code_ok) begin
				goff_q[char_code[CW-1:0]] <= table_addr;
				gadv_q[char_code[CW-1:0]] <= table_word;
			end
			code_q <= char_code[CW-1:0];
			dir_q <= direction;
		end
		if (cmd.mem_rd) rd_q <= mem[addr_q];
		adv_q <= gadv_q[code_q];
		off_q <= goff_q[code_q];
		if (cmd.addr_load) addr_q <= AW'({22'd0, off_q} % STROKE_WORDS);
		else if (cmd.addr_inc) addr_q <= AW'(({1'b0, addr_q} + 1'b1) % STROKE_WORDS);
		if (cmd.latch_x) x_q <= rd_q;
		if (cmd.latch_y) y_q <= rd_q;
		if (cmd.latch_op) opc_q <= {rd_q[31:16] == 16'd1, rd_q[31:16] == 16'd0 ||
			rd_q[31:16] == 16'hffff && rd_q[15:0] != 0};
		if (cmd.mul_go) prod_s1 <= 64'(ma) * 64'(mb);
		unique case (cmd.acc)
			AC_NONE: ;
			AC_AX: ax_q <= sat32(66'(rp));
			AC_PX: px_q <= sat32(66'(rp));
			AC_PY: py_q <= sat32(66'(rp));
			AC_CLR_PEN: sum_q <= 66'(pen_q[cmd.row]);
			AC_ADD: sum_q <= sum_q + 66'(rp);
			AC_SAT_V: sum_q <= 66'(sat32(sum_q));
			AC_SAT_PEN: sum_q <= 66'(sat32(sum_q + 66'(rp)));
			default: ;
		endcase
	end

	// opc_q: [1] drawto, [0] moveto, from the opcode word truncated toward zero
	assign sts.is_move = opc_q[0];
	assign sts.is_draw = opc_q[1];
	assign rp = qrnd(prod_s1);
	assign acc_out = sum_q[31:0];
	assign pen_out = pen_q;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.msel)
			MS_ADV_SX: begin ma = adv_q; mb = regs_q[REG_SCALE_X]; end
			MS_AX_DIR: begin ma = ax_q; mb = dir_q; end
			MS_X_SX:   begin ma = x_q; mb = regs_q[REG_SCALE_X]; end
			MS_Y_SY:   begin ma = y_q; mb = regs_q[REG_SCALE_Y]; end
			MS_MAT_PX: begin ma = regs_q[{cmd.row, 1'b0} + 3'd2]; mb = px_q; end
			MS_MAT_PY: begin ma = regs_q[{cmd.row, 1'b0} + 3'd3]; mb = py_q; end
			MS_MAT_AX: begin ma = regs_q[{cmd.row, 1'b0} + 3'd2]; mb = ax_q; end
			default: ;
		endcase
	end
endmodule

// ===== rtl/core/sfvg_ctrl.sv =====
// Controller: sequences loads, stroke walk, transform and pen advance,
// and drives the output register. Depends on sfvg_pkg.
module sfvg_ctrl import sfvg_pkg::*; #(
	parameter int MAX_GLYPH_OPS = MAX_GLYPH_OPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [2:0]         op,
	input  sts_t               sts,
	input  logic               present,
	input  logic signed [31:0] acc_out,
	input  logic signed [31:0] pen_in [3],
	output cmd_t               cmd,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [1:0]         kind,
	output logic signed [31:0] vx,
	output logic signed [31:0] vy,
	output logic signed [31:0] vz,
	output logic               m_last,
	output logic               ovf
);
	typedef enum logic [4:0] {
		IDLE, LOOK, ADVM, ADVR, ADVD, ADVDR, RD_OP, LT_OP, DECIDE, RD_X, LT_X,
		RD_Y, LT_Y, MX, MXR, MY, MYR, ROW0, RM1, RM2, RM3, RSAT, EMIT, EMIT_END,
		PA0, PA1, PA2, PA3, ENDS, DONE, WAIT
	} state_t;

	localparam int CNTW = $clog2(MAX_GLYPH_OPS + 1);

	state_t          state_q;
	logic [CNTW-1:0] cnt_q;
	logic            strip_q, move_q, isdraw_q, ovf_q;
	logic [1:0]      row_q;
	logic signed [31:0] v_q [3];
	logic            cons;
	logic            out_load;

	assign s_tready = (state_q == IDLE);
	assign cons = !m_tvalid || m_tready;
	assign out_load = cons && (state_q == EMIT_END || state_q == ENDS || state_q == DONE ||
		(state_q == EMIT && (move_q || strip_q)));

	always_comb begin
		cmd = '0;
		cmd.row = row_q;
		unique case (state_q)
			LOOK:  ;
			ADVM:  begin cmd.msel = MS_ADV_SX; cmd.mul_go = 1'b1; end
			ADVR:  cmd.acc = AC_AX;
			ADVD:  begin cmd.msel = MS_AX_DIR; cmd.mul_go = 1'b1; end
			ADVDR: begin cmd.acc = AC_AX; cmd.ax_dir = 1'b1; cmd.addr_load = 1'b1; end
			RD_OP: begin cmd.mem_rd = 1'b1; cmd.addr_inc = 1'b1; end
			LT_OP: cmd.latch_op = 1'b1;
			RD_X:  begin cmd.mem_rd = 1'b1; cmd.addr_inc = 1'b1; end
			LT_X:  cmd.latch_x = 1'b1;
			RD_Y:  begin cmd.mem_rd = 1'b1; cmd.addr_inc = 1'b1; end
			LT_Y:  cmd.latch_y = 1'b1;
			MX:    begin cmd.msel = MS_X_SX; cmd.mul_go = 1'b1; end
			MXR:   cmd.acc = AC_PX;
			MY:    begin cmd.msel = MS_Y_SY; cmd.mul_go = 1'b1; end
			MYR:   cmd.acc = AC_PY;
			ROW0:  begin cmd.acc = AC_CLR_PEN; cmd.msel = MS_MAT_PX; cmd.mul_go = 1'b1; end
			RM1:   begin cmd.acc = AC_ADD; cmd.msel = MS_MAT_PY; cmd.mul_go = 1'b1; end
			RM2:   cmd.acc = AC_ADD;
			RM3:   cmd.acc = AC_SAT_V;
			PA0:   begin cmd.acc = AC_CLR_PEN; cmd.msel = MS_MAT_AX; cmd.mul_go = 1'b1; end
			PA1:   cmd.acc = AC_SAT_PEN;
			PA2:   cmd.pen_wr = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			m_tvalid <= 1'b0;
			cnt_q <= '0;
			strip_q <= 1'b0;
			row_q <= '0;
			isdraw_q <= 1'b0;
			move_q <= 1'b0;
			ovf_q <= 1'b0;
			ovf <= 1'b0;
			kind <= KIND_DONE;
			m_last <= 1'b0;
			vx <= '0; vy <= '0; vz <= '0;
			v_q <= '{32'sd0, 32'sd0, 32'sd0};
		end else begin
			if (out_load) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				IDLE: if (s_tvalid) begin
					cnt_q <= '0;
					strip_q <= 1'b0;
					ovf_q <= 1'b0;
					isdraw_q <= (op == OP_DRAW);
					if (op == OP_DRAW || op == OP_INDENT) state_q <= LOOK;
				end
				LOOK: state_q <= present ? ADVM : DONE;
				ADVM: state_q <= ADVR;
				ADVR: state_q <= isdraw_q ? ADVDR : ADVD;
				ADVD: state_q <= ADVDR;
				ADVDR: begin
					row_q <= '0;
					state_q <= isdraw_q ? RD_OP : PA0;
				end
				RD_OP: state_q <= LT_OP;
				LT_OP: state_q <= DECIDE;
				DECIDE: begin
					move_q <= sts.is_move;
					if (!sts.is_move && !sts.is_draw) begin
						row_q <= '0; state_q <= PA0;
					end else if (cnt_q >= CNTW'(MAX_GLYPH_OPS)) begin
						ovf_q <= 1'b1; row_q <= '0; state_q <= PA0;
					end else begin
						cnt_q <= cnt_q + 1'b1; state_q <= RD_X;
					end
				end
				RD_X: state_q <= LT_X;
				LT_X: state_q <= RD_Y;
				RD_Y: state_q <= LT_Y;
				LT_Y: state_q <= MX;
				MX: state_q <= MXR;
				MXR: state_q <= MY;
				MY: state_q <= MYR;
				MYR: begin row_q <= '0; state_q <= ROW0; end
				ROW0: state_q <= RM1;
				RM1: state_q <= RM2;
				RM2: state_q <= RM3;
				RM3: state_q <= RSAT;
				RSAT: begin
					v_q[row_q] <= acc_out;
					if (row_q == 2'd2) state_q <= (move_q && strip_q) ? EMIT_END : EMIT;
					else begin row_q <= row_q + 1'b1; state_q <= ROW0; end
				end
				EMIT_END: if (cons) begin
					kind <= KIND_END; m_last <= 1'b0; ovf <= 1'b0;
					vx <= '0; vy <= '0; vz <= '0; state_q <= EMIT;
				end
				EMIT: if (move_q || strip_q) begin
					if (cons) begin
						kind <= move_q ? KIND_BEGIN : KIND_VERT; ovf <= 1'b0;
						m_last <= 1'b0; vx <= v_q[0]; vy <= v_q[1]; vz <= v_q[2];
						strip_q <= 1'b1; state_q <= RD_OP;
					end
				end else state_q <= RD_OP;
				PA0: state_q <= PA1;
				PA1: state_q <= PA2;
				PA2: begin
					if (row_q == 2'd2) state_q <= strip_q ? ENDS : DONE;
					else begin row_q <= row_q + 1'b1; state_q <= PA0; end
				end
				ENDS: if (cons) begin
					kind <= KIND_END; m_last <= 1'b0; ovf <= 1'b0;
					vx <= '0; vy <= '0; vz <= '0; state_q <= DONE;
				end
				DONE: if (cons) begin
					kind <= KIND_DONE; m_last <= 1'b1; ovf <= ovf_q;
					vx <= pen_in[0]; vy <= pen_in[1]; vz <= pen_in[2];
					state_q <= WAIT;
				end
				WAIT: state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/stroke_font_vector_generator.sv =====
// Top level of the stroke font vector generator.
// Instantiates sfvg_ctrl and sfvg_datapath; uses sfvg_pkg.
// One item at a time; s_tready is high only while idle. Loads, set pen and
// unused op codes finish on acceptance. A draw does its setup, reads every
// opcode word (the stop word included), transforms each moveto/drawto vertex
// (the shared multiplier does two scales and six matrix products per vertex)
// and emits an end first where a moveto closes a strip; then come pen advance,
// closing end strip and done transaction. An indent does setup and pen advance,
// an absent glyph neither. Each result waits while m_tready is low.
module stroke_font_vector_generator import sfvg_pkg::*; #(
	parameter int STROKE_WORDS  = STROKE_WORDS_DEF,
	parameter int CHAR_CODES    = CHAR_CODES_DEF,
	parameter int MAX_GLYPH_OPS = MAX_GLYPH_OPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op[2:0] char_code[10:3] table_addr[20:11] table_word[52:21] glyph_present[53]
	// pos_x[85:54] pos_y[117:86] pos_z[149:118] direction[181:150], zero to 183
	input  logic [183:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// kind[1:0] vx[33:2] vy[65:34] vz[97:66] overflow[98], zero to 103
	output logic [103:0] m_tdata,
	output logic         m_tlast
);
	cmd_t cmd;
	sts_t sts;
	logic present, ovf;
	logic [1:0] kind;
	logic signed [31:0] acc_out, vx, vy, vz;
	logic signed [31:0] pen [3];

	assign m_tdata = {5'd0, ovf, vz, vy, vx, kind};

	sfvg_datapath #(.STROKE_WORDS(STROKE_WORDS), .CHAR_CODES(CHAR_CODES)) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data(signed'(cfg_data)),
		.in_acc(s_tvalid && s_tready), .op(s_tdata[2:0]), .char_code(s_tdata[10:3]),
		.table_addr(s_tdata[20:11]), .table_word(signed'(s_tdata[52:21])),
		.glyph_present(s_tdata[53]), .pos_x(signed'(s_tdata[85:54])),
		.pos_y(signed'(s_tdata[117:86])), .pos_z(signed'(s_tdata[149:118])),
		.direction(signed'(s_tdata[181:150])), .cmd, .sts, .present, .acc_out,
		.pen_out(pen)
	);

	sfvg_ctrl #(.MAX_GLYPH_OPS(MAX_GLYPH_OPS)) u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .op(s_tdata[2:0]), .sts, .present,
		.acc_out, .pen_in(pen), .cmd, .m_tvalid, .m_tready, .kind, .vx, .vy, .vz,
		.m_last(m_tlast), .ovf
	);
endmodule
